// File: hw/rtl/stsg_pkg.sv
// Shared types, constants and arithmetic helpers for the sine tone generator.
package stsg_pkg;

  localparam int unsigned RegCount = 5;
  localparam int unsigned MaxChannels = 8;

  typedef enum logic [2:0] {
    REG_SAMPLE_RATE    = 3'd0,
    REG_TONE_FREQUENCY = 3'd1,
    REG_VOLUME         = 3'd2,
    REG_CHANNEL_COUNT  = 3'd3,
    REG_SAMPLE_FORMAT  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PER_DIV,
    ST_MOD_DIV,
    ST_MUL_PF,
    ST_REM_DIV,
    ST_PHASE_DIV,
    ST_X2,
    ST_POLY_MUL,
    ST_POLY_SUB,
    ST_SINE,
    ST_SCALE,
    ST_FORMAT,
    ST_PUSH
  } eng_state_t;

  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598670;
  localparam logic [31:0] C5 = 32'd85569301;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;

  // Polynomial coefficients in Horner order after C9.
  function automatic logic [31:0] poly_coef(input logic [1:0] i);
    case (i)
      2'd0: poly_coef = C7;
      2'd1: poly_coef = C5;
      2'd2: poly_coef = C3;
      default: poly_coef = C1;
    endcase
  endfunction

  // Tick handed from the front end to the sample engine.
  typedef struct packed {
    logic [11:0] sample_index;
  } tick_t;

  // Computed sample handed to the channel emitter.
  typedef struct packed {
    logic [31:0] bits;
    logic [11:0] sample_index;
    logic [3:0]  channels;
    logic        is_float;
  } sample_t;

endpackage

// File: hw/rtl/stsg_fifo.sv
// Small synchronous queue between the stages.
module stsg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != CW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: hw/rtl/stsg_engine.sv
// Sample engine: period, phase, quarter-wave polynomial, scaling and formatting.
module stsg_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [17:0]           sample_rate,
  input  logic [22:0]           tone_frequency,
  input  logic [15:0]           volume,
  input  logic [3:0]            channels,
  input  logic                  is_float,
  input  logic                  tick_valid,
  output logic                  tick_ready,
  input  stsg_pkg::tick_t       tick,
  output logic                  smp_valid,
  input  logic                  smp_ready,
  output stsg_pkg::sample_t     smp
);
  import stsg_pkg::*;

  eng_state_t st_r, st_nxt;

  logic [31:0] pos_r;
  logic [25:0] den_r;
  logic [22:0] f_r;
  logic [11:0] idx_r;
  logic [3:0]  ch_r;
  logic        flt_r;
  logic [15:0] vol_r;

  // shared restoring divider: quotient/remainder of num_r by dvs_r
  logic [55:0] num_r;
  logic [55:0] quo_r;
  logic [55:0] rem_r;
  logic [25:0] dvs_r;
  logic [5:0]  bit_r;

  logic [15:0] phase_r;
  logic [31:0] x_r, x2_r, t_r;
  logic [63:0] mul_r;
  logic [1:0]  ci_r;
  logic        neg_r;
  logic [30:0] m_r;
  logic [31:0] bits_r;
  logic [4:0]  fb_r;

  logic [56:0] rem_sh;
  logic        fits;
  logic [55:0] rem_fin;
  logic [31:0] dividend_pos;

  assign rem_sh = {rem_r, num_r[bit_r]};
  assign fits = rem_sh >= {31'd0, dvs_r};
  assign rem_fin = fits ? 56'(rem_sh - {31'd0, dvs_r}) : 56'(rem_sh);
  assign dividend_pos = pos_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (tick_valid) st_nxt = ST_PER_DIV;
      ST_PER_DIV:   if (bit_r == 6'd0) st_nxt = ST_MOD_DIV;
      ST_MOD_DIV:   if (bit_r == 6'd0) st_nxt = ST_MUL_PF;
      ST_MUL_PF:    st_nxt = ST_REM_DIV;
      ST_REM_DIV:   if (bit_r == 6'd0) st_nxt = ST_PHASE_DIV;
      ST_PHASE_DIV: if (bit_r == 6'd0) st_nxt = ST_X2;
      ST_X2:        st_nxt = ST_POLY_MUL;
      ST_POLY_MUL:  st_nxt = ST_POLY_SUB;
      ST_POLY_SUB:  st_nxt = (ci_r == 2'd3) ? ST_SINE : ST_POLY_MUL;
      ST_SINE:      st_nxt = ST_SCALE;
      ST_SCALE:     st_nxt = ST_FORMAT;
      ST_FORMAT:    if (!flt_r || m_r == '0 || m_r[30]) st_nxt = ST_PUSH;
      ST_PUSH:      if (smp_ready) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tick_ready = (st_r == ST_IDLE);
    smp_valid = (st_r == ST_PUSH);
    smp.bits = bits_r;
    smp.sample_index = idx_r;
    smp.channels = ch_r;
    smp.is_float = flt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pos_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_MOD_DIV && bit_r == 6'd0 && rem_fin == 56'd0)
        pos_r <= '0;
      if (st_r == ST_PUSH && smp_ready) pos_r <= pos_r + 1'b1;
    end
  end

  logic [23:0] mant;
  logic [6:0]  rbits;
  logic        rup;
  logic [24:0] mant_r1;
  logic [7:0]  expo;
  logic [47:0] s16_prod;
  logic [15:0] mag16;
  logic [14:0] xm;
  logic [31:0] xv;
  logic [63:0] xsq;
  logic [31:0] rnd;
  logic [15:0] sq15;

  always_comb begin
    mant = m_r[30:7];
    rbits = m_r[6:0];
    rup = rbits[6] && (rbits[5:0] != 6'd0 || mant[0]);
    mant_r1 = {1'b0, mant} + {24'd0, rup};
    expo = 8'd127 - {3'd0, fb_r};
    s16_prod = {17'd0, m_r} * 48'd65535;
    mag16 = s16_prod[46:31];
    xm = phase_r[14] ? 15'(15'd16384 - {1'b0, phase_r[13:0]}) : {1'b0, phase_r[13:0]};
    xv = {1'b0, xm, 16'd0};
    xsq = {32'd0, xv} * {32'd0, xv};
    rnd = mul_r[61:30] + 32'd16384;
    sq15 = (rnd[31:15] > 17'd32767) ? 16'd32767 : rnd[30:15];
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (tick_valid) begin
        idx_r <= tick.sample_index;
        ch_r <= (channels == 4'd0) ? 4'd1
              : (channels > 4'(MaxChannels)) ? 4'(MaxChannels) : channels;
        flt_r <= is_float;
        vol_r <= (volume > 16'd32768) ? 16'd32768 : volume;
        f_r <= (tone_frequency == '0) ? 23'd1 : tone_frequency;
        den_r <= {((sample_rate == '0) ? 18'd1 : sample_rate), 8'd0};
        num_r <= {30'd0, ((sample_rate == '0) ? 18'd1 : sample_rate), 8'd0};
        dvs_r <= {3'd0, ((tone_frequency == '0) ? 23'd1 : tone_frequency)};
        rem_r <= '0;
        quo_r <= '0;
        bit_r <= 6'd25;
      end
      ST_PER_DIV, ST_MOD_DIV, ST_REM_DIV, ST_PHASE_DIV: begin
        rem_r <= rem_fin;
        quo_r <= {quo_r[54:0], fits};
        if (bit_r != 6'd0) bit_r <= bit_r - 1'b1;
        else begin
          rem_r <= '0;
          quo_r <= '0;
          if (st_r == ST_PER_DIV) begin
            num_r <= {24'd0, dividend_pos};
            dvs_r <= ({quo_r[24:0], fits} == 26'd0) ? 26'd1 : {quo_r[24:0], fits};
            bit_r <= 6'd31;
          end else if (st_r == ST_REM_DIV) begin
            num_r <= rem_fin << 16;
            bit_r <= 6'd41;
          end else if (st_r == ST_PHASE_DIV) begin
            phase_r <= {quo_r[14:0], fits};
          end
        end
      end
      ST_MUL_PF: begin
        num_r <= {24'd0, pos_r} * {33'd0, f_r};
        dvs_r <= den_r;
        bit_r <= 6'd54;
      end
      ST_X2: begin
        x_r <= xv;
        x2_r <= xsq[61:30];
        neg_r <= phase_r[15];
        t_r <= C9;
        ci_r <= 2'd0;
      end
      ST_POLY_MUL: mul_r <= {32'd0, x2_r} * {32'd0, t_r};
      ST_POLY_SUB: begin
        t_r <= poly_coef(ci_r) - mul_r[61:30];
        ci_r <= ci_r + 1'b1;
      end
      ST_SINE: mul_r <= {32'd0, x_r} * {32'd0, t_r};
      ST_SCALE: begin
        m_r <= {15'd0, sq15} * {15'd0, vol_r};
        fb_r <= 5'd0;
      end
      ST_FORMAT: begin
        if (!flt_r) begin
          bits_r <= neg_r ? {16'd0, 16'(16'd0 - mag16)} : {16'd0, mag16};
        end else if (m_r == '0) begin
          bits_r <= '0;
        end else if (!m_r[30]) begin
          m_r <= {m_r[29:0], 1'b0};
          fb_r <= fb_r + 1'b1;
        end else begin
          bits_r <= mant_r1[24] ? {neg_r, 8'(expo + 8'd1), 23'd0}
                                : {neg_r, expo, mant_r1[22:0]};
        end
      end
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/stsg_emitter.sv
// Channel emitter: fans one sample out to every channel with its byte offset.
module stsg_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              smp_valid,
  output logic              smp_ready,
  input  stsg_pkg::sample_t smp,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,
  output logic              out_tlast
);
  import stsg_pkg::*;

  logic [2:0]  k_r;
  logic [16:0] base;
  logic [16:0] off;
  logic        last;

  assign base = {5'd0, smp.sample_index} * {13'd0, smp.channels};
  assign off = smp.is_float ? 17'((base + {14'd0, k_r}) << 2) : 17'((base + {14'd0, k_r}) << 1);
  assign last = ({1'b0, k_r} + 4'd1 == smp.channels);

  assign out_tvalid = smp_valid;
  assign out_tdata = {4'd0, k_r, off, smp.bits};
  assign out_tlast = last;
  assign smp_ready = out_tready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else if (smp_valid && out_tready) k_r <= last ? 3'd0 : k_r + 1'b1;
  end
endmodule

// File: hw/rtl/sine_tone_sample_generator.sv
// Top level of the sine tone sample generator.
// channel | ports         | payload
// in      | in_t*         | tdata[11:0] sample_index
// out     | out_t*        | tdata sample_bits, byte_offset, channel_index; tlast last_of_run
// cfg     | cfg_p*        | APB registers at 4*i
// One tick passes through four bit-serial divisions (26, 32, 55 and 42 steps),
// eight polynomial steps and up to 30 float normalize steps.
// Each result then leaves at one per cycle, one per channel, while out_tready is high.
// Reset is synchronous, active low; position counter clears to zero.
// A stalled output holds the emitter; the input queue takes ticks meanwhile.
module sine_tone_sample_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] sample_bits, [48:32] byte_offset, [51:49] channel_index
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stsg_pkg::*;

  logic [17:0] rate_r;
  logic [22:0] freq_r;
  logic [15:0] vol_r;
  logic [3:0]  chan_r;
  logic        fmt_r;
  logic        wr;
  logic [3:0]  chan_cl;
  tick_t       tk_in, tk;
  logic        tk_valid, tk_ready;
  sample_t     smp;
  logic        smp_valid, smp_ready;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign chan_cl = (chan_r > 4'(MaxChannels)) ? 4'(MaxChannels) : chan_r;
  // 12-bit index wraps at the buffer size of 4096 samples
  assign tk_in.sample_index = in_tdata[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 18'd44100;
      freq_r <= 23'd112640;
      vol_r <= '0;
      chan_r <= 4'd1;
      fmt_r <= 1'b0;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_SAMPLE_RATE:    rate_r <= cfg_pwdata[17:0];
        REG_TONE_FREQUENCY: freq_r <= cfg_pwdata[22:0];
        REG_VOLUME:         vol_r <= cfg_pwdata[15:0];
        REG_CHANNEL_COUNT:  chan_r <= cfg_pwdata[3:0];
        REG_SAMPLE_FORMAT:  fmt_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SAMPLE_RATE:    cfg_prdata = {14'd0, rate_r};
      REG_TONE_FREQUENCY: cfg_prdata = {9'd0, freq_r};
      REG_VOLUME:         cfg_prdata = {16'd0, vol_r};
      REG_CHANNEL_COUNT:  cfg_prdata = {28'd0, chan_r};
      REG_SAMPLE_FORMAT:  cfg_prdata = {31'd0, fmt_r};
      default:            cfg_prdata = '0;
    endcase
  end

  stsg_fifo #(.Width($bits(tick_t)), .Depth(4)) u_q (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(tk_in),
    .rd_valid(tk_valid), .rd_ready(tk_ready), .rd_data(tk)
  );

  stsg_engine u_eng (
    .clk, .rst_n,
    .sample_rate(rate_r), .tone_frequency(freq_r), .volume(vol_r),
    .channels(chan_cl), .is_float(fmt_r),
    .tick_valid(tk_valid), .tick_ready(tk_ready), .tick(tk),
    .smp_valid, .smp_ready, .smp
  );

  stsg_emitter u_emit (
    .clk, .rst_n,
    .smp_valid, .smp_ready, .smp,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule
